// ===== design/chs_pkg.sv =====
// Shared widths, constants, types and the arctangent table of the compass heading block.
package chs_pkg;

  localparam int unsigned CordicStagesDefault = 16;
  localparam int unsigned AtanLen             = 24;

  localparam int unsigned AxisW  = 13;  // sensor axis reading
  localparam int unsigned FoldW  = 14;  // axis after the quarter-turn fold
  localparam int unsigned ScaleW = 16;  // fraction bits added to the axes
  localparam int unsigned VecW   = 32;  // CORDIC x/y datapath
  localparam int unsigned AngW   = 24;  // angle, centidegrees with 8 fraction bits
  localparam int unsigned FracW  = 8;
  localparam int unsigned HeadW  = 16;
  localparam int unsigned DeclW  = 16;
  localparam int unsigned SumW   = 18;  // angle plus declination
  localparam int unsigned IdxW   = 5;   // index into the arctangent table

  localparam logic signed [AngW-1:0]  QuarterTurn = 24'sd2304000;
  localparam logic signed [AngW-1:0]  HalfLsb     = 24'sd128;
  localparam logic signed [SumW-1:0]  FullTurn    = 18'sd36000;
  localparam logic signed [DeclW-1:0] DeclReset   = 16'sd862;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } chs_vec_t;

  // atan(2^-i) in degrees * 25600, rounded to nearest
  function automatic logic signed [AngW-1:0] atan_lut(input logic [IdxW-1:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:    v = 24'sd1152000;
      5'd1:    v = 24'sd680065;
      5'd2:    v = 24'sd359328;
      5'd3:    v = 24'sd182400;
      5'd4:    v = 24'sd91554;
      5'd5:    v = 24'sd45822;
      5'd6:    v = 24'sd22916;
      5'd7:    v = 24'sd11459;
      5'd8:    v = 24'sd5730;
      5'd9:    v = 24'sd2865;
      5'd10:   v = 24'sd1432;
      5'd11:   v = 24'sd716;
      5'd12:   v = 24'sd358;
      5'd13:   v = 24'sd179;
      5'd14:   v = 24'sd90;
      5'd15:   v = 24'sd45;
      5'd16:   v = 24'sd22;
      5'd17:   v = 24'sd11;
      5'd18:   v = 24'sd6;
      5'd19:   v = 24'sd3;
      5'd20:   v = 24'sd1;
      5'd21:   v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/chs_axes_if.sv =====
// Valid/ready channel carrying one magnetometer sample.
interface chs_axes_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] x_axis;
  logic signed [12:0] y_axis;

  modport source (output valid, output x_axis, output y_axis, input ready);
  modport sink   (input valid, input x_axis, input y_axis, output ready);
endinterface

// ===== design/chs_heading_if.sv =====
// Valid/ready channel carrying one heading result.
interface chs_heading_if;
  logic        valid;
  logic        ready;
  logic [15:0] heading_centideg;

  modport source (output valid, output heading_centideg, input ready);
  modport sink   (input valid, input heading_centideg, output ready);
endinterface

// ===== design/chs_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation.
module chs_cordic_stage
  import chs_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  chs_vec_t vec_i,
  output logic     valid_o,
  output chs_vec_t vec_o
);

  logic signed [VecW-1:0] dx;
  logic signed [VecW-1:0] dy;
  logic signed [AngW-1:0] ang;
  chs_vec_t               vec_d;
  chs_vec_t               vec_q;
  logic                   valid_q;

  always_comb begin
    dx  = $signed(vec_i.y) >>> SHIFT;
    dy  = $signed(vec_i.x) >>> SHIFT;
    ang = atan_lut(IdxW'(SHIFT));
    vec_d      = vec_i;
    // rotate towards the x axis; direction set by the sign of y
    if (!vec_i.y[VecW-1]) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + ang;
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

// ===== design/compass_heading_from_axes_top.sv =====
// Compass heading: one sample per cycle in while the pipeline is not stalled, one heading per
// sample out. The stages, in order: fold stage, one stage per CORDIC micro-rotation,
// round/declination/wrap stage. Each stage holds its item while the stage after it is
// full and stalled; empty stages fill behind a stalled output, so bubbles close up.
// The declination register is used at the last stage and must be written only while
// the pipeline is empty. A zero vector gives the declination alone.
module compass_heading_from_axes_top
  import chs_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CordicStagesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  chs_axes_if.sink                 axes_i,
  chs_heading_if.source            heading_o,
  input  logic                     cfg_we_i,
  input  logic signed [DeclW-1:0]  cfg_wdata_i
);

  localparam int unsigned LastStage = CORDIC_STAGES + 1;

  logic [LastStage:0]  valid;
  logic [LastStage:0]  en;
  chs_vec_t            vec [CORDIC_STAGES+1];

  logic signed [DeclW-1:0] decl_q;

  // Declination register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= DeclReset;
    end else if (cfg_we_i) begin
      decl_q <= cfg_wdata_i;
    end
  end

  // Stage enables: a stage advances when it is empty or the next one advances
  assign en[LastStage] = ~valid[LastStage] | heading_o.ready;
  for (genvar j = 0; j < LastStage; j++) begin : g_en
    assign en[j] = ~valid[j] | en[j+1];
  end
  assign axes_i.ready = en[0];

  // Fold stage: bring the vector into the right half-plane and scale
  logic signed [FoldW-1:0] xa;
  logic signed [FoldW-1:0] ya;
  logic signed [FoldW-1:0] xf;
  logic signed [FoldW-1:0] yf;
  chs_vec_t                fold_d;
  chs_vec_t                fold_q;
  logic                    fold_valid_q;

  always_comb begin
    xa     = FoldW'(axes_i.x_axis);
    ya     = FoldW'(axes_i.y_axis);
    xf     = xa;
    yf     = ya;
    fold_d = '0;
    if (xa[FoldW-1]) begin
      if (!ya[FoldW-1]) begin
        xf       = ya;
        yf       = -xa;
        fold_d.z = QuarterTurn;
      end else begin
        xf       = -ya;
        yf       = xa;
        fold_d.z = -QuarterTurn;
      end
    end
    fold_d.x    = {{(VecW-FoldW-ScaleW){xf[FoldW-1]}}, xf, {ScaleW{1'b0}}};
    fold_d.y    = {{(VecW-FoldW-ScaleW){yf[FoldW-1]}}, yf, {ScaleW{1'b0}}};
    fold_d.zero = (axes_i.x_axis == '0) && (axes_i.y_axis == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
    end else if (en[0]) begin
      fold_valid_q <= axes_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fold_q <= fold_d;
    end
  end

  assign valid[0] = fold_valid_q;
  assign vec[0]   = fold_q;

  // CORDIC micro-rotations
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    chs_cordic_stage #(
      .SHIFT (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[k+1]),
      .valid_i (valid[k]),
      .vec_i   (vec[k]),
      .valid_o (valid[k+1]),
      .vec_o   (vec[k+1])
    );
  end

  // Round, add declination, wrap once, clamp
  logic signed [AngW-1:0] z_rnd;
  logic signed [SumW-1:0] ang;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] wrap;
  logic [HeadW-1:0]       head_d;
  logic [HeadW-1:0]       head_q;
  logic                   head_valid_q;

  always_comb begin
    z_rnd = (vec[CORDIC_STAGES].z + HalfLsb) >>> FracW;
    ang   = vec[CORDIC_STAGES].zero ? '0 : z_rnd[SumW-1:0];
    sum   = ang + SumW'(decl_q);
    if (sum[SumW-1]) begin
      wrap = sum + FullTurn;
    end else if (sum > FullTurn) begin
      wrap = sum - FullTurn;
    end else begin
      wrap = sum;
    end
    if (wrap[SumW-1]) begin
      head_d = '0;
    end else if (wrap > FullTurn) begin
      head_d = FullTurn[HeadW-1:0];
    end else begin
      head_d = wrap[HeadW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else if (en[LastStage]) begin
      head_valid_q <= valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LastStage]) begin
      head_q <= head_d;
    end
  end

  assign valid[LastStage]           = head_valid_q;
  assign heading_o.valid            = head_valid_q;
  assign heading_o.heading_centideg = head_q;

endmodule

// ===== design/chs_checker.sv =====
// Port-level checks on the compass heading block, bound to its top level.
module chs_checker
  import chs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [HeadW-1:0] heading_i
);

  // result always in the heading range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (heading_i <= FullTurn[HeadW-1:0]))
    else $error("heading beyond a full turn");

  // an empty output stage means nothing in the pipeline can be blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output stage");

  // a stalled result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("stalled item dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(heading_i))
    else $error("stalled item changed");

endmodule

bind compass_heading_from_axes_top chs_checker u_chs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (axes_i.ready),
  .out_valid_i (heading_o.valid),
  .out_ready_i (heading_o.ready),
  .heading_i   (heading_o.heading_centideg)
);
